// File: sv/sha_pkg.sv
`timescale 1ns / 1ps

package sha_pkg;

  typedef logic [0:7][31:0] sha_words_t;
  typedef logic [0:15][31:0] sha_window_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_ZERO,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_ADD
  } sha_state_e;

  typedef struct packed {
    logic       ld_en;
    logic [7:0] ld_byte;
    logic       round_en;
    logic [5:0] round;
    logic       init_wk;
    logic       add_hash;
    logic       fin;
  } sha_ctl_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;

  // word 0 sits in the most significant bits
  localparam sha_words_t SHA_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// File: sv/sha_if.sv
`timescale 1ns / 1ps

interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: sv/sha256_message_hasher_unit.sv
`timescale 1ns / 1ps

// channel  dir  handshake            payload
// msg_i    in   msg_i.valid/ready    data_byte, byte_present, end_of_message
// dig_o    out  dig_o.valid/ready    digest_word, word_index, last_word
//
// each message byte takes one cycle; every full 64-byte block then holds off input for the
// working-word load, 64 rounds of the shared round unit and the hash add
// the end marker adds byte-wise padding plus one or two such compressions
// the eight digest words drain from their own buffer while the next message streams in;
// a second digest waits in the add step until that buffer is empty
// reset is asynchronous, active low, and restores the initial hash values

module sha256_message_hasher_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    msg_i,
  sha_out_if.source dig_o
);

  sha_pkg::sha_ctl_t   ctl;
  sha_pkg::sha_words_t hsum;
  sha_pkg::sha_words_t dig_q;
  logic [31:0]         wt;
  logic [2:0]          out_idx_q, out_idx_d;
  logic                out_busy_q, out_busy_d;

  sha_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (msg_i.valid),
    .data_byte_i      (msg_i.data_byte),
    .byte_present_i   (msg_i.byte_present),
    .end_of_message_i (msg_i.end_of_message),
    .out_busy_i       (out_busy_q),
    .in_ready_o       (msg_i.ready),
    .ctl_o            (ctl)
  );

  sha_sched u_sched (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .wt_o  (wt)
  );

  sha_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .wt_i   (wt),
    .hsum_o (hsum)
  );

  assign dig_o.valid       = out_busy_q;
  assign dig_o.digest_word = dig_q[out_idx_q];
  assign dig_o.word_index  = out_idx_q;
  assign dig_o.last_word   = (out_idx_q == 3'd7);

  always_comb begin
    out_idx_d  = out_idx_q;
    out_busy_d = out_busy_q;
    if (ctl.fin) begin
      out_idx_d  = '0;
      out_busy_d = 1'b1;
    end else if (dig_o.valid && dig_o.ready) begin
      out_idx_d = out_idx_q + 3'd1;
      if (out_idx_q == 3'd7) begin
        out_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fin) begin
      dig_q <= hsum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_idx_q  <= '0;
      out_busy_q <= 1'b0;
    end else begin
      out_idx_q  <= out_idx_d;
      out_busy_q <= out_busy_d;
    end
  end

endmodule

// File: sv/sha_sched.sv
`timescale 1ns / 1ps

module sha_sched (
  input  logic              clk_i,
  input  sha_pkg::sha_ctl_t ctl_i,
  output logic [31:0]       wt_o
);

  sha_pkg::sha_window_t w_q, w_d;
  logic [511:0]         flat;
  logic [31:0]          nw;

  assign flat = w_q;
  assign wt_o = w_q[0];

  // next schedule word from the sixteen-word window, oldest word at index 0
  assign nw = sha_pkg::small_sig1(w_q[14]) + w_q[9] + sha_pkg::small_sig0(w_q[1]) + w_q[0];

  always_comb begin
    w_d = w_q;
    if (ctl_i.ld_en) begin
      w_d = {flat[503:0], ctl_i.ld_byte};
    end else if (ctl_i.round_en) begin
      w_d = {flat[479:0], nw};
    end
  end

  always_ff @(posedge clk_i) begin
    w_q <= w_d;
  end

endmodule

// File: sv/sha_round.sv
`timescale 1ns / 1ps

module sha_round (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha_pkg::sha_ctl_t   ctl_i,
  input  logic [31:0]         wt_i,
  output sha_pkg::sha_words_t hsum_o
);

  sha_pkg::sha_words_t wk_q, wk_d;
  sha_pkg::sha_words_t hash_q, hash_d;
  logic [31:0]         t1, t2, ch, maj;

  assign ch  = (wk_q[4] & wk_q[5]) ^ (~wk_q[4] & wk_q[6]);
  assign maj = (wk_q[0] & wk_q[1]) ^ (wk_q[0] & wk_q[2]) ^ (wk_q[1] & wk_q[2]);
  assign t1  = wk_q[7] + sha_pkg::big_sig1(wk_q[4]) + ch + sha_pkg::SHA_K[ctl_i.round] + wt_i;
  assign t2  = sha_pkg::big_sig0(wk_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hsum_o[i] = hash_q[i] + wk_q[i];
    end
  end

  always_comb begin
    wk_d = wk_q;
    if (ctl_i.init_wk) begin
      wk_d = hash_q;
    end else if (ctl_i.round_en) begin
      wk_d[0] = t1 + t2;
      wk_d[1] = wk_q[0];
      wk_d[2] = wk_q[1];
      wk_d[3] = wk_q[2];
      wk_d[4] = wk_q[3] + t1;
      wk_d[5] = wk_q[4];
      wk_d[6] = wk_q[5];
      wk_d[7] = wk_q[6];
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (ctl_i.fin) begin
      hash_d = sha_pkg::SHA_INIT;
    end else if (ctl_i.add_hash) begin
      hash_d = hsum_o;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_q <= wk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= sha_pkg::SHA_INIT;
    end else begin
      hash_q <= hash_d;
    end
  end

endmodule

// File: sv/sha_ctrl.sv
`timescale 1ns / 1ps

module sha_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [7:0]        data_byte_i,
  input  logic              byte_present_i,
  input  logic              end_of_message_i,
  input  logic              out_busy_i,
  output logic              in_ready_o,
  output sha_pkg::sha_ctl_t ctl_o
);

  sha_pkg::sha_state_e state_q, state_d;
  sha_pkg::sha_state_e after_q, after_d;
  logic                fin_q, fin_d;
  logic [5:0]          fill_q, fill_d;
  logic [5:0]          round_q, round_d;
  logic [63:0]         len_q, len_d;
  logic                acc;
  logic                wrap;

  // input is only taken while idle
  assign acc  = in_valid_i & (state_q == sha_pkg::ST_IDLE);
  assign wrap = (fill_q == sha_pkg::LAST_POS);

  // next state
  always_comb begin
    state_d = state_q;
    after_d = after_q;
    fin_d   = fin_q;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        if (acc) begin
          if (byte_present_i && wrap) begin
            state_d = sha_pkg::ST_LOAD;
            after_d = end_of_message_i ? sha_pkg::ST_MARK : sha_pkg::ST_IDLE;
          end else if (end_of_message_i) begin
            state_d = sha_pkg::ST_MARK;
          end
        end
      end
      sha_pkg::ST_MARK: begin
        if (wrap) begin
          state_d = sha_pkg::ST_LOAD;
          after_d = sha_pkg::ST_ZERO;
        end else begin
          state_d = sha_pkg::ST_ZERO;
        end
      end
      sha_pkg::ST_ZERO: begin
        if (fill_q == sha_pkg::LEN_POS) begin
          state_d = sha_pkg::ST_LEN;
        end else if (wrap) begin
          state_d = sha_pkg::ST_LOAD;
          after_d = sha_pkg::ST_ZERO;
        end
      end
      sha_pkg::ST_LEN: begin
        if (wrap) begin
          state_d = sha_pkg::ST_LOAD;
          after_d = sha_pkg::ST_IDLE;
          fin_d   = 1'b1;
        end
      end
      sha_pkg::ST_LOAD: begin
        state_d = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        if (round_q == sha_pkg::LAST_ROUND) begin
          state_d = sha_pkg::ST_ADD;
        end
      end
      sha_pkg::ST_ADD: begin
        if (!fin_q) begin
          state_d = after_q;
        end else if (!out_busy_i) begin
          state_d = sha_pkg::ST_IDLE;
          fin_d   = 1'b0;
        end
      end
      default: begin
        state_d = sha_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    ctl_o      = '0;
    ctl_o.round = round_q;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        ctl_o.ld_en   = acc & byte_present_i;
        ctl_o.ld_byte = data_byte_i;
      end
      sha_pkg::ST_MARK: begin
        ctl_o.ld_en   = 1'b1;
        ctl_o.ld_byte = sha_pkg::PAD_MARK;
      end
      sha_pkg::ST_ZERO: begin
        ctl_o.ld_en   = (fill_q != sha_pkg::LEN_POS);
        ctl_o.ld_byte = 8'h00;
      end
      sha_pkg::ST_LEN: begin
        ctl_o.ld_en   = 1'b1;
        ctl_o.ld_byte = len_q[63:56];
      end
      sha_pkg::ST_LOAD: begin
        ctl_o.init_wk = 1'b1;
      end
      sha_pkg::ST_ROUND: begin
        ctl_o.round_en = 1'b1;
      end
      sha_pkg::ST_ADD: begin
        ctl_o.add_hash = ~fin_q;
        ctl_o.fin      = fin_q & ~out_busy_i;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // fill position, bit length and round counter
  always_comb begin
    fill_d  = fill_q;
    len_d   = len_q;
    round_d = round_q;
    if (ctl_o.ld_en) begin
      fill_d = fill_q + 6'd1;
    end
    if (state_q == sha_pkg::ST_IDLE && ctl_o.ld_en) begin
      len_d = len_q + 64'd8;
    end else if (state_q == sha_pkg::ST_LEN) begin
      // length bytes leave from the top, so the count is zero once all eight are out
      len_d = {len_q[55:0], 8'h00};
    end
    if (ctl_o.init_wk) begin
      round_d = '0;
    end else if (ctl_o.round_en) begin
      round_d = round_q + 6'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha_pkg::ST_IDLE;
      after_q <= sha_pkg::ST_IDLE;
      fin_q   <= 1'b0;
      fill_q  <= '0;
      round_q <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      fin_q   <= fin_d;
      fill_q  <= fill_d;
      round_q <= round_d;
      len_q   <= len_d;
    end
  end

endmodule

// File: dv/tb_sha256_message_hasher_unit.sv
`timescale 1ns / 1ps

module tb_sha256_message_hasher_unit;

  localparam int unsigned CLK_PERIOD = 12;
  localparam int unsigned RESET_CYCLES = 9;
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned LONG_HOLD_CYCLES = 600;
  localparam int unsigned RUN_LIMIT_CYCLES = 500000;

  localparam logic [31:0] HASH_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_item_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  sha_in_if  msg_if ();
  sha_out_if dig_if ();

  sha256_message_hasher_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .msg_i  (msg_if),
    .dig_o  (dig_if)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // running hash of the message being streamed in
  logic [31:0]  chain_words [8];
  logic [7:0]   block_buf [64];
  int unsigned  block_fill;
  logic [63:0]  bit_count;
  digest_item_t pending_digest_words [$];

  int unsigned error_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left = 0;
  bit          hold_pending = 1'b0;
  int unsigned random_items = 0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block_buf();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    {a, b, c, d, e, f, g, h} = {chain_words[0], chain_words[1], chain_words[2],
                                chain_words[3], chain_words[4], chain_words[5],
                                chain_words[6], chain_words[7]};
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g;
      g = f;
      f = e;
      e = d + t1;
      d = c;
      c = b;
      b = a;
      a = t1 + t2;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
    chain_words[4] += e;
    chain_words[5] += f;
    chain_words[6] += g;
    chain_words[7] += h;
  endfunction

  function automatic void restart_message();
    for (int j = 0; j < 8; j++) chain_words[j] = HASH_IV[j];
    block_fill = 0;
    bit_count = '0;
  endfunction

  // feeds one accepted item into the running hash; queues the digest at message end
  function automatic void absorb_item(input logic [7:0] data, input logic present,
                                      input logic eom);
    digest_item_t item;
    if (present) begin
      block_buf[block_fill] = data;
      bit_count += 64'd8;
      block_fill = (block_fill + 1) % 64;
      if (block_fill == 0) compress_block_buf();
    end
    if (!eom) return;
    block_buf[block_fill] = 8'h80;
    for (int j = block_fill + 1; j < 64; j++) block_buf[j] = 8'h00;
    // no room left for the length field, so it goes into an extra block
    if (block_fill >= 56) begin
      compress_block_buf();
      for (int j = 0; j < 64; j++) block_buf[j] = 8'h00;
    end
    for (int j = 0; j < 8; j++) block_buf[56+j] = bit_count[63 - 8*j -: 8];
    compress_block_buf();
    for (int j = 0; j < 8; j++) begin
      item.word = chain_words[j];
      item.index = 3'(j);
      item.last = (j == 7);
      pending_digest_words.insert(pending_digest_words.size(), item);
    end
    restart_message();
  endfunction

  function automatic void check_digest_item(input logic [31:0] word, input logic [2:0] index,
                                            input logic last);
    digest_item_t want;
    if (pending_digest_words.size() == 0) begin
      $error("unexpected digest item: digest_word %h word_index %0d last_word %0b",
             word, index, last);
      error_count++;
      return;
    end
    want = pending_digest_words.pop_front();
    if (word !== want.word) begin
      $error("digest_word mismatch: expected %h, got %h", want.word, word);
      error_count++;
    end
    if (index !== want.index) begin
      $error("word_index mismatch: expected %0d, got %0d", want.index, index);
      error_count++;
    end
    if (last !== want.last) begin
      $error("last_word mismatch: expected %0b, got %0b", want.last, last);
      error_count++;
    end
  endfunction

  // digest receiver: random back-pressure, long holds on request, result checking
  always @(posedge clk_i) begin
    if (rst_ni && dig_if.valid && dig_if.ready) begin
      check_digest_item(dig_if.digest_word, dig_if.word_index, dig_if.last_word);
    end
    if (hold_pending) begin
      hold_left = LONG_HOLD_CYCLES;
      hold_pending = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      dig_if.ready <= 1'b0;
    end else begin
      dig_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
    while ($urandom_range(99) < send_idle_pct) begin
      msg_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    msg_if.valid <= 1'b1;
    msg_if.data_byte <= data;
    msg_if.byte_present <= present;
    msg_if.end_of_message <= eom;
    do @(posedge clk_i); while (!msg_if.ready);
    absorb_item(data, present, eom);
    if (present || eom) random_items++;
  endtask

  // random bytes; the end marker rides on the last byte or comes as a bare item
  task automatic send_message(input int unsigned len, input int unsigned noise_pct);
    bit end_on_byte;
    end_on_byte = 1'($urandom_range(1));
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, end_on_byte && (i == len - 1));
    end
    if (len == 0 || !end_on_byte) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    msg_if.valid <= 1'b0;
    while (pending_digest_words.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);               // empty message
    send_item(8'h5a, 1'b0, 1'b0);               // ignored item
    send_item(8'ha5, 1'b0, 1'b1);               // empty again, stray data
    send_item(8'h00, 1'b1, 1'b1);               // byte and end together
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);               // end without byte
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'hc3, 1'b0, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    wait_drained();
  endtask

  // one full block mid-message, then a tail whose length field spills into a second block
  task automatic test_padding_edges();
    send_message(120, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                     input int unsigned budget);
    int unsigned start;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    start = random_items;
    while (random_items - start < budget) begin
      send_message($urandom_range(4), 10);
    end
    wait_drained();
  endtask

  // receiver stalls long enough that a digest parks in the add step and input backs up
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(negedge clk_i);
    hold_pending = 1'b1;
    @(posedge clk_i);
    for (int m = 0; m < 3; m++) send_message($urandom_range(2, 1), 0);
    wait_drained();
  endtask

  initial begin
    rst_ni = 1'b0;
    msg_if.valid = 1'b0;
    msg_if.data_byte = '0;
    msg_if.byte_present = 1'b0;
    msg_if.end_of_message = 1'b0;
    dig_if.ready = 1'b0;
    restart_message();
    for (int j = 0; j < 64; j++) block_buf[j] = 8'h00;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_padding_edges();
    test_output_backpressure();
    test_random_traffic(8, 55, 6);
    test_random_traffic(55, 8, 6);
    test_random_traffic(0, 0, 6);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("sha256_message_hasher_unit verification clean");
    end else begin
      $display("sha256_message_hasher_unit verification failed");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * RUN_LIMIT_CYCLES);
    $display("sha256_message_hasher_unit verification failed");
    $finish;
  end

endmodule

// File: files.f
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_sched.sv
sv/sha_round.sv
sv/sha_ctrl.sv
sv/sha256_message_hasher_unit.sv
dv/tb_sha256_message_hasher_unit.sv
